/* src/mbq_pkg.sv */
// ----------------------------------------------------------------------------
// mbq_pkg - shared types and constants of the multichannel biquad
// Field widths, register map, form codes and the per-form term sequences
// that drive the shared multiply-accumulate pipeline.
// ----------------------------------------------------------------------------
package mbq_pkg;

   localparam int CHAN_W   = 3;
   localparam int SAMPLE_W = 24;
   localparam int COEF_W   = 32;
   localparam int WORD_W   = 32;
   localparam int PROD_W   = 64;
   localparam int ACC_W    = 68;
   localparam int CSR_AW   = 5;
   localparam int CSR_DW   = 32;
   localparam int STEP_W   = 4;

   localparam logic [1:0] FORM_DF1 = 2'd0;
   localparam logic [1:0] FORM_DF2 = 2'd1;
   localparam logic [1:0] FORM_TF1 = 2'd2;
   localparam logic [1:0] FORM_TF2 = 2'd3;

   localparam logic [2:0] REG_FORM = 3'd0;
   localparam logic [2:0] REG_B0   = 3'd1;
   localparam logic [2:0] REG_B1   = 3'd2;
   localparam logic [2:0] REG_B2   = 3'd3;
   localparam logic [2:0] REG_FB1  = 3'd4;
   localparam logic [2:0] REG_FB2  = 3'd5;

   localparam logic [1:0]        FORM_RESET = FORM_TF2;
   localparam logic [COEF_W-1:0] B0_RESET   = 32'h1000_0000;

   typedef enum logic [1:0] {
      K_NOP,
      K_MUL,
      K_PLAIN
   } term_kind_type;

   typedef enum logic [3:0] {
      SRC_X,
      SRC_IN1,
      SRC_IN2,
      SRC_OUT1,
      SRC_OUT2,
      SRC_MID1,
      SRC_MID2,
      SRC_W,
      SRC_Y
   } term_src_type;

   typedef enum logic [2:0] {
      CF_B0,
      CF_B1,
      CF_B2,
      CF_FB1,
      CF_FB2
   } term_coef_type;

   typedef enum logic [2:0] {
      D_W,
      D_Y,
      D_IN1,
      D_IN2,
      D_OUT1,
      D_OUT2,
      D_MID1,
      D_MID2
   } term_dest_type;

   typedef struct packed {
      term_kind_type kind;
      term_src_type  src;
      term_coef_type coef;
      logic          last;
      term_dest_type dest;
   } term_op_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] in1;
      logic signed [WORD_W-1:0] in2;
      logic signed [WORD_W-1:0] out1;
      logic signed [WORD_W-1:0] out2;
      logic signed [WORD_W-1:0] mid1;
      logic signed [WORD_W-1:0] mid2;
   } chan_state_type;

   function automatic term_op_type mk_op(input term_kind_type kind, input term_src_type src,
                                         input term_coef_type coef, input logic last,
                                         input term_dest_type dest);
      term_op_type op;
      op.kind = kind;
      op.src  = src;
      op.coef = coef;
      op.last = last;
      op.dest = dest;
      return op;
   endfunction

   // one term per step; nop beyond the sequence lets the pipeline drain
   function automatic term_op_type prog_op(input logic [1:0] form,
                                           input logic [STEP_W-1:0] step);
      term_op_type op;
      op = mk_op(K_NOP, SRC_X, CF_B0, 1'b0, D_W);
      case (form)
         FORM_DF1: begin
            case (step)
               4'd0:    op = mk_op(K_MUL,   SRC_X,    CF_B0,  1'b0, D_Y);
               4'd1:    op = mk_op(K_MUL,   SRC_IN1,  CF_B1,  1'b0, D_Y);
               4'd2:    op = mk_op(K_MUL,   SRC_IN2,  CF_B2,  1'b0, D_Y);
               4'd3:    op = mk_op(K_MUL,   SRC_OUT1, CF_FB1, 1'b0, D_Y);
               4'd4:    op = mk_op(K_MUL,   SRC_OUT2, CF_FB2, 1'b1, D_Y);
               4'd5:    op = mk_op(K_PLAIN, SRC_IN1,  CF_B0,  1'b1, D_IN2);
               4'd6:    op = mk_op(K_PLAIN, SRC_X,    CF_B0,  1'b1, D_IN1);
               4'd7:    op = mk_op(K_PLAIN, SRC_OUT1, CF_B0,  1'b1, D_OUT2);
               4'd8:    op = mk_op(K_PLAIN, SRC_Y,    CF_B0,  1'b1, D_OUT1);
               default: op = mk_op(K_NOP,   SRC_X,    CF_B0,  1'b0, D_W);
            endcase
         end
         FORM_DF2: begin
            case (step)
               4'd0:    op = mk_op(K_PLAIN, SRC_X,    CF_B0,  1'b0, D_W);
               4'd1:    op = mk_op(K_MUL,   SRC_MID1, CF_FB1, 1'b0, D_W);
               4'd2:    op = mk_op(K_MUL,   SRC_MID2, CF_FB2, 1'b1, D_W);
               4'd3:    op = mk_op(K_MUL,   SRC_MID1, CF_B1,  1'b0, D_Y);
               4'd4:    op = mk_op(K_MUL,   SRC_MID2, CF_B2,  1'b0, D_Y);
               4'd5:    op = mk_op(K_MUL,   SRC_W,    CF_B0,  1'b1, D_Y);
               4'd6:    op = mk_op(K_PLAIN, SRC_MID1, CF_B0,  1'b1, D_MID2);
               4'd7:    op = mk_op(K_PLAIN, SRC_W,    CF_B0,  1'b1, D_MID1);
               default: op = mk_op(K_NOP,   SRC_X,    CF_B0,  1'b0, D_W);
            endcase
         end
         FORM_TF1: begin
            case (step)
               4'd0:    op = mk_op(K_PLAIN, SRC_X,    CF_B0,  1'b0, D_W);
               4'd1:    op = mk_op(K_PLAIN, SRC_MID2, CF_B0,  1'b1, D_W);
               4'd4:    op = mk_op(K_MUL,   SRC_W,    CF_B0,  1'b0, D_Y);
               4'd5:    op = mk_op(K_PLAIN, SRC_IN2,  CF_B0,  1'b1, D_Y);
               4'd6:    op = mk_op(K_MUL,   SRC_W,    CF_B1,  1'b0, D_IN2);
               4'd7:    op = mk_op(K_PLAIN, SRC_IN1,  CF_B0,  1'b1, D_IN2);
               4'd8:    op = mk_op(K_MUL,   SRC_W,    CF_FB1, 1'b0, D_MID2);
               4'd9:    op = mk_op(K_PLAIN, SRC_MID1, CF_B0,  1'b1, D_MID2);
               4'd10:   op = mk_op(K_MUL,   SRC_W,    CF_B2,  1'b1, D_IN1);
               4'd11:   op = mk_op(K_MUL,   SRC_W,    CF_FB2, 1'b1, D_MID1);
               default: op = mk_op(K_NOP,   SRC_X,    CF_B0,  1'b0, D_W);
            endcase
         end
         FORM_TF2: begin
            case (step)
               4'd0:    op = mk_op(K_MUL,   SRC_X,    CF_B0,  1'b0, D_Y);
               4'd1:    op = mk_op(K_PLAIN, SRC_IN2,  CF_B0,  1'b1, D_Y);
               4'd2:    op = mk_op(K_MUL,   SRC_X,    CF_B1,  1'b0, D_IN2);
               4'd3:    op = mk_op(K_PLAIN, SRC_IN1,  CF_B0,  1'b0, D_IN2);
               4'd4:    op = mk_op(K_MUL,   SRC_Y,    CF_FB1, 1'b1, D_IN2);
               4'd5:    op = mk_op(K_MUL,   SRC_X,    CF_B2,  1'b0, D_IN1);
               4'd6:    op = mk_op(K_MUL,   SRC_Y,    CF_FB2, 1'b1, D_IN1);
               default: op = mk_op(K_NOP,   SRC_X,    CF_B0,  1'b0, D_W);
            endcase
         end
         default: op = mk_op(K_NOP, SRC_X, CF_B0, 1'b0, D_W);
      endcase
      return op;
   endfunction

   // step at which the last result lands in its register
   function automatic logic [STEP_W-1:0] prog_end(input logic [1:0] form);
      logic [STEP_W-1:0] n;
      case (form)
         FORM_DF1: n = 4'd10;
         FORM_DF2: n = 4'd9;
         FORM_TF1: n = 4'd13;
         FORM_TF2: n = 4'd8;
         default:  n = 4'd8;
      endcase
      return n;
   endfunction

   // round half up to Q9.23 and saturate to 32 bits
   function automatic logic signed [WORD_W-1:0] round_sat(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0]  t;
      logic signed [ACC_W-29:0] q;
      logic signed [WORD_W-1:0] r;
      t = v + 68'sd134217728;
      q = t[ACC_W-1:28];
      if (q[ACC_W-29:WORD_W-1] == '0 || q[ACC_W-29:WORD_W-1] == '1) begin
         r = q[WORD_W-1:0];
      end else if (q[ACC_W-29]) begin
         r = 32'sh8000_0000;
      end else begin
         r = 32'sh7fff_ffff;
      end
      return r;
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] sat24(input logic signed [WORD_W-1:0] v);
      logic signed [SAMPLE_W-1:0] r;
      if (v[WORD_W-1:SAMPLE_W-1] == '0 || v[WORD_W-1:SAMPLE_W-1] == '1) begin
         r = v[SAMPLE_W-1:0];
      end else if (v[WORD_W-1]) begin
         r = 24'sh80_0000;
      end else begin
         r = 24'sh7f_ffff;
      end
      return r;
   endfunction

endpackage

/* src/mbq_req_if.sv */
// ----------------------------------------------------------------------------
// mbq_req_if - sample input channel
// Valid/ready channel carrying a channel number and one Q1.23 sample.
// ----------------------------------------------------------------------------
interface mbq_req_if;
   import mbq_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [CHAN_W-1:0]          chan;
   logic signed [SAMPLE_W-1:0] sample_in;

   modport source (output valid, output chan, output sample_in, input ready);
   modport sink   (input valid, input chan, input sample_in, output ready);
endinterface

/* src/mbq_rsp_if.sv */
// ----------------------------------------------------------------------------
// mbq_rsp_if - filtered sample output channel
// Valid/ready channel carrying a channel number and one Q1.23 sample.
// ----------------------------------------------------------------------------
interface mbq_rsp_if;
   import mbq_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [CHAN_W-1:0]          chan_out;
   logic signed [SAMPLE_W-1:0] sample_out;

   modport source (output valid, output chan_out, output sample_out, input ready);
   modport sink   (input valid, input chan_out, input sample_out, output ready);
endinterface

/* src/multichannel_biquad_four_forms_top.sv */
// ----------------------------------------------------------------------------
// multichannel_biquad_four_forms_top - multichannel biquad, four structures
// Per-channel second-order IIR section with selectable structure.
// ----------------------------------------------------------------------------
// Each item is one Q1.23 sample for one channel; the block returns one
// saturated Q1.23 sample for that channel. Items are handled one at a time.
// An item passes through acceptance, the state memory read, the
// multiply-accumulate pipeline and a last step that writes state back and
// loads the output register. The pipeline steps through L term slots,
// where L is the number of term slots of the structure: 9 for direct
// form I, 8 for direct form II, 12 for transposed form I, two of them
// idle while w settles, and 7 for transposed form II. A channel number
// beyond NUM_CHANNELS bypasses the pipeline, leaves channel state as it
// is and returns zero. All terms share the single 32x32 multiplier, which
// takes one term per cycle, in a three-stage multiply, accumulate and
// round pipeline. Channel state sits in one memory of NUM_CHANNELS entries;
// per-entry valid bits make reset and any write of the structure register
// clear it at once, with no clearing pass. A finished
// item waits in the output register while the next item is accepted.
// ----------------------------------------------------------------------------
module multichannel_biquad_four_forms_top #(
   parameter int unsigned NUM_CHANNELS = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   mbq_req_if.sink                       req_port,
   mbq_rsp_if.source                     rsp_port,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [mbq_pkg::CSR_AW-1:0]    paddr,
   input  logic [mbq_pkg::CSR_DW-1:0]    pwdata,
   output logic [mbq_pkg::CSR_DW-1:0]    prdata,
   output logic                          pready
);
   import mbq_pkg::*;

   localparam int ADDR_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_LOAD = 4'b0010,
      ST_RUN  = 4'b0100,
      ST_DONE = 4'b1000
   } seq_state_type;

   // configuration registers
   logic [1:0]               form_ff;
   logic signed [COEF_W-1:0] b0_ff, b1_ff, b2_ff, fb1_ff, fb2_ff;
   logic                     csr_wr;
   logic [2:0]               csr_idx;

   assign pready  = 1'b1;
   assign csr_idx = paddr[4:2];
   assign csr_wr  = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         form_ff <= FORM_RESET;
         b0_ff   <= B0_RESET;
         b1_ff   <= '0;
         b2_ff   <= '0;
         fb1_ff  <= '0;
         fb2_ff  <= '0;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_FORM: form_ff <= pwdata[1:0];
            REG_B0:   b0_ff   <= pwdata;
            REG_B1:   b1_ff   <= pwdata;
            REG_B2:   b2_ff   <= pwdata;
            REG_FB1:  fb1_ff  <= pwdata;
            REG_FB2:  fb2_ff  <= pwdata;
            default:  ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_FORM: prdata = {30'b0, form_ff};
         REG_B0:   prdata = b0_ff;
         REG_B1:   prdata = b1_ff;
         REG_B2:   prdata = b2_ff;
         REG_FB1:  prdata = fb1_ff;
         REG_FB2:  prdata = fb2_ff;
         default:  prdata = '0;
      endcase
   end

   // sequencer
   seq_state_type     state_ff, state_in;
   logic [STEP_W-1:0] step_ff;
   logic              req_accept;
   logic              chan_ok;
   logic              bad_ff;
   logic [ADDR_W+CHAN_W-1:0] chan_ext;
   logic [ADDR_W-1:0] rd_addr;
   logic [ADDR_W-1:0] addr_ff;
   logic [CHAN_W-1:0] chan_ff;
   logic signed [SAMPLE_W-1:0] sample_ff;
   logic              fin_load;

   assign req_port.ready = (state_ff == ST_IDLE);
   assign req_accept     = req_port.valid && req_port.ready;
   assign chan_ext       = {{ADDR_W{1'b0}}, req_port.chan};
   assign rd_addr        = chan_ext[ADDR_W-1:0];
   assign chan_ok        = (32'(req_port.chan) < NUM_CHANNELS);
   assign fin_load       = (state_ff == ST_DONE) && (!rsp_port.valid || rsp_port.ready);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = chan_ok ? ST_LOAD : ST_DONE;
            end
         end
         ST_LOAD: state_in = ST_RUN;
         ST_RUN: begin
            if (step_ff == prog_end(form_ff)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (fin_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_RUN) begin
            step_ff <= step_ff + 4'd1;
         end else begin
            step_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         addr_ff   <= rd_addr;
         chan_ff   <= req_port.chan;
         sample_ff <= req_port.sample_in;
         bad_ff    <= !chan_ok;
      end
   end

   // channel state memory with valid bits
   chan_state_type    mem [NUM_CHANNELS];
   chan_state_type    rd_data_ff;
   logic              rd_valid_ff;
   logic [NUM_CHANNELS-1:0] valid_ff;
   logic              mem_we;
   chan_state_type    s_ff, n_ff;

   assign mem_we = fin_load && !bad_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[addr_ff] <= n_ff;
      end
      if (req_accept) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (csr_wr && csr_idx == REG_FORM)) begin
         valid_ff <= '0;
      end else if (mem_we) begin
         valid_ff[addr_ff] <= 1'b1;
      end
      if (req_accept) begin
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   // stage 1: operand and coefficient select, multiply
   term_op_type              op_now, op1_ff;
   logic signed [WORD_W-1:0] opnd, w_ff, y_ff, x_word;
   logic signed [COEF_W-1:0] coef;
   logic signed [PROD_W-1:0] prod_in, prod_ff;

   assign x_word = {{(WORD_W-SAMPLE_W){sample_ff[SAMPLE_W-1]}}, sample_ff};

   always_comb begin
      if (state_ff == ST_RUN) begin
         op_now = prog_op(form_ff, step_ff);
      end else begin
         op_now = mk_op(K_NOP, SRC_X, CF_B0, 1'b0, D_W);
      end
      case (op_now.src)
         SRC_X:    opnd = x_word;
         SRC_IN1:  opnd = s_ff.in1;
         SRC_IN2:  opnd = s_ff.in2;
         SRC_OUT1: opnd = s_ff.out1;
         SRC_OUT2: opnd = s_ff.out2;
         SRC_MID1: opnd = s_ff.mid1;
         SRC_MID2: opnd = s_ff.mid2;
         SRC_W:    opnd = w_ff;
         SRC_Y:    opnd = y_ff;
         default:  opnd = '0;
      endcase
      case (op_now.coef)
         CF_B0:   coef = b0_ff;
         CF_B1:   coef = b1_ff;
         CF_B2:   coef = b2_ff;
         CF_FB1:  coef = fb1_ff;
         CF_FB2:  coef = fb2_ff;
         default: coef = '0;
      endcase
      if (op_now.kind == K_PLAIN) begin
         prod_in = {{(PROD_W-WORD_W-28){opnd[WORD_W-1]}}, opnd, 28'b0};
      end else begin
         prod_in = opnd * coef;
      end
   end

   // stage 2: accumulate; stage 3: round, saturate, store
   logic signed [ACC_W-1:0]  acc_ff, sum, sum_ff;
   logic                     fin_ff;
   term_dest_type            fdest_ff;
   logic signed [WORD_W-1:0] res;

   assign sum = acc_ff + {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
   assign res = round_sat(sum_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         op1_ff <= mk_op(K_NOP, SRC_X, CF_B0, 1'b0, D_W);
         fin_ff <= 1'b0;
      end else begin
         op1_ff <= op_now;
         fin_ff <= (op1_ff.kind != K_NOP) && op1_ff.last;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (state_ff == ST_LOAD) begin
         acc_ff <= '0;
      end else if (op1_ff.kind != K_NOP) begin
         if (op1_ff.last) begin
            acc_ff   <= '0;
            sum_ff   <= sum;
            fdest_ff <= op1_ff.dest;
         end else begin
            acc_ff <= sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_LOAD) begin
         s_ff <= rd_valid_ff ? rd_data_ff : '0;
         n_ff <= rd_valid_ff ? rd_data_ff : '0;
      end else if (fin_ff) begin
         case (fdest_ff)
            D_W:     w_ff      <= res;
            D_Y:     y_ff      <= res;
            D_IN1:   n_ff.in1  <= res;
            D_IN2:   n_ff.in2  <= res;
            D_OUT1:  n_ff.out1 <= res;
            D_OUT2:  n_ff.out2 <= res;
            D_MID1:  n_ff.mid1 <= res;
            D_MID2:  n_ff.mid2 <= res;
            default: ;
         endcase
      end
   end

   // output register
   logic rsp_valid_ff, rsp_valid_in;
   logic [CHAN_W-1:0] rsp_chan_ff;
   logic signed [SAMPLE_W-1:0] rsp_sample_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fin_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && rsp_port.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (fin_load) begin
         rsp_chan_ff   <= chan_ff;
         rsp_sample_ff <= bad_ff ? '0 : sat24(y_ff);
      end
   end

   assign rsp_port.valid      = rsp_valid_ff;
   assign rsp_port.chan_out   = rsp_chan_ff;
   assign rsp_port.sample_out = rsp_sample_ff;

endmodule

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench - multichannel biquad, four structures
// Drives channel-tagged Q1.23 samples through the filter under random source
// and sink stalls. Every accepted item is run through a bit-true filter
// predictor kept here, and each returned sample is compared against the
// oldest expected one. Coefficients and structure change between phases
// over the register port, only while the filter is drained.
// ----------------------------------------------------------------------------
module testbench;
   import mbq_pkg::*;

   localparam int          CHANNELS       = 8;
   localparam int          ITEMS_PER_SEG  = 78;
   localparam int          SEGMENTS       = 12;
   localparam int          WATCHDOG_LIMIT = 2000;
   localparam logic [2:0]  REG_SPARE6     = 3'd6;
   localparam logic [2:0]  REG_SPARE7     = 3'd7;

   typedef logic signed [79:0] wide_type;

   localparam wide_type HALF_ULP = 80'sd134217728;
   localparam wide_type WORD_MAX = 80'sd2147483647;
   localparam wide_type WORD_MIN = -80'sd2147483648;

   typedef struct packed {
      logic [CHAN_W-1:0]          chan;
      logic signed [SAMPLE_W-1:0] smp;
   } filtered_type;

   typedef enum logic {ROW_CSR, ROW_ITEM} row_kind_type;

   typedef struct packed {
      row_kind_type               kind;
      logic [2:0]                 idx;
      logic [31:0]                data;
      logic [CHAN_W-1:0]          ch;
      logic signed [SAMPLE_W-1:0] smp;
      logic                       fixed;
      logic signed [SAMPLE_W-1:0] want;
   } plan_row_type;

   logic clock = 1'b0;
   logic reset;

   logic                psel;
   logic                penable;
   logic                pwrite;
   logic [CSR_AW-1:0]   paddr;
   logic [CSR_DW-1:0]   pwdata;
   logic [CSR_DW-1:0]   prdata;
   logic                pready;

   mbq_req_if req_bus ();
   mbq_rsp_if rsp_bus ();

   multichannel_biquad_four_forms_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // filter settings and per-channel history as the block should hold them
   logic [1:0]         form_cur;
   logic signed [31:0] tap_b0, tap_b1, tap_b2, tap_fb1, tap_fb2;
   logic signed [31:0] hist_in1  [CHANNELS];
   logic signed [31:0] hist_in2  [CHANNELS];
   logic signed [31:0] hist_out1 [CHANNELS];
   logic signed [31:0] hist_out2 [CHANNELS];
   logic signed [31:0] hist_mid1 [CHANNELS];
   logic signed [31:0] hist_mid2 [CHANNELS];

   filtered_type pending_out [$];
   plan_row_type plan [$];
   int           mismatches = 0;
   int           quiet_cycles = 0;
   int unsigned  send_idle_pct = 0;
   int unsigned  recv_idle_pct = 0;

   function automatic void clear_history();
      for (int i = 0; i < CHANNELS; i++) begin
         hist_in1[i]  = '0;
         hist_in2[i]  = '0;
         hist_out1[i] = '0;
         hist_out2[i] = '0;
         hist_mid1[i] = '0;
         hist_mid2[i] = '0;
      end
   endfunction

   function automatic wide_type mul_term(input logic signed [31:0] s,
                                         input logic signed [31:0] c);
      wide_type ws;
      wide_type wc;
      ws = s;
      wc = c;
      return ws * wc;
   endfunction

   function automatic wide_type plain_term(input logic signed [31:0] s);
      wide_type ws;
      ws = s;
      return ws <<< 28;
   endfunction

   // round half up from Q*.51 to Q9.23, clip to 32 bits
   function automatic logic signed [31:0] to_q923(input wide_type v);
      wide_type           q;
      logic signed [31:0] r;
      q = (v + HALF_ULP) >>> 28;
      if (q > WORD_MAX) begin
         r = 32'sh7fff_ffff;
      end else if (q < WORD_MIN) begin
         r = 32'sh8000_0000;
      end else begin
         r = q[31:0];
      end
      return r;
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] clip24(input logic signed [31:0] v);
      logic signed [SAMPLE_W-1:0] r;
      if (v > 32'sd8388607) begin
         r = 24'sh7f_ffff;
      end else if (v < -32'sd8388608) begin
         r = 24'sh80_0000;
      end else begin
         r = v[SAMPLE_W-1:0];
      end
      return r;
   endfunction

   function automatic filtered_type filter_sample(input logic [CHAN_W-1:0] ch,
                                                  input logic signed [SAMPLE_W-1:0] smp);
      filtered_type       res;
      logic signed [31:0] x, y, w, n2, m2;
      int                 k;
      x = smp;
      k = ch;
      y = '0;
      res.chan = ch;
      if (k >= CHANNELS) begin
         res.smp = '0;
      end else begin
         case (form_cur)
            FORM_DF1: begin
               y = to_q923(mul_term(x, tap_b0) + mul_term(hist_in1[k], tap_b1)
                           + mul_term(hist_in2[k], tap_b2)
                           + mul_term(hist_out1[k], tap_fb1)
                           + mul_term(hist_out2[k], tap_fb2));
               hist_in2[k]  = hist_in1[k];
               hist_in1[k]  = x;
               hist_out2[k] = hist_out1[k];
               hist_out1[k] = y;
            end
            FORM_DF2: begin
               w = to_q923(plain_term(x) + mul_term(hist_mid1[k], tap_fb1)
                           + mul_term(hist_mid2[k], tap_fb2));
               y = to_q923(mul_term(w, tap_b0) + mul_term(hist_mid1[k], tap_b1)
                           + mul_term(hist_mid2[k], tap_b2));
               hist_mid2[k] = hist_mid1[k];
               hist_mid1[k] = w;
            end
            FORM_TF1: begin
               w  = to_q923(plain_term(x) + plain_term(hist_mid2[k]));
               y  = to_q923(mul_term(w, tap_b0) + plain_term(hist_in2[k]));
               n2 = to_q923(mul_term(w, tap_b1) + plain_term(hist_in1[k]));
               m2 = to_q923(mul_term(w, tap_fb1) + plain_term(hist_mid1[k]));
               hist_in2[k]  = n2;
               hist_mid2[k] = m2;
               hist_in1[k]  = to_q923(mul_term(w, tap_b2));
               hist_mid1[k] = to_q923(mul_term(w, tap_fb2));
            end
            FORM_TF2: begin
               y  = to_q923(mul_term(x, tap_b0) + plain_term(hist_in2[k]));
               n2 = to_q923(mul_term(x, tap_b1) + plain_term(hist_in1[k])
                            + mul_term(y, tap_fb1));
               hist_in1[k] = to_q923(mul_term(x, tap_b2) + mul_term(y, tap_fb2));
               hist_in2[k] = n2;
            end
            default: ;
         endcase
         res.smp = clip24(y);
      end
      return res;
   endfunction

   task automatic report_mismatch(input string what, input int want, input int got);
      mismatches++;
      $display("%0t error: %s expected %0d got %0d", $time, what, want, got);
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] data);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         REG_FORM: begin
            form_cur = data[1:0];
            clear_history();
         end
         REG_B0:  tap_b0  = data;
         REG_B1:  tap_b1  = data;
         REG_B2:  tap_b2  = data;
         REG_FB1: tap_fb1 = data;
         REG_FB2: tap_fb2 = data;
         default: ;
      endcase
   endtask

   task automatic send_sample(input logic [CHAN_W-1:0] ch,
                              input logic signed [SAMPLE_W-1:0] smp,
                              input logic fixed,
                              input logic signed [SAMPLE_W-1:0] want);
      filtered_type due;
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.chan      <= ch;
      req_bus.sample_in <= smp;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      due = filter_sample(ch, smp);
      if (fixed) begin
         due.smp = want;
      end
      pending_out.push_back(due);
   endtask

   // hold the source off until every filtered item is back
   task automatic drain_filter();
      req_bus.valid <= 1'b0;
      while (pending_out.size() != 0) @(posedge clock);
   endtask

   function automatic void add_csr(input logic [2:0] idx, input logic [31:0] data);
      plan_row_type r;
      r = '0;
      r.kind = ROW_CSR;
      r.idx  = idx;
      r.data = data;
      plan.push_back(r);
   endfunction

   function automatic void add_item(input logic [CHAN_W-1:0] ch,
                                    input logic signed [SAMPLE_W-1:0] smp,
                                    input logic fixed,
                                    input logic signed [SAMPLE_W-1:0] want);
      plan_row_type r;
      r = '0;
      r.kind  = ROW_ITEM;
      r.ch    = ch;
      r.smp   = smp;
      r.fixed = fixed;
      r.want  = want;
      plan.push_back(r);
   endfunction

   function automatic logic [31:0] pick_tap(input int style, input logic feedback);
      logic [31:0] c;
      case (style)
         0: c = $urandom;
         1: begin
            if (feedback) begin
               c = $urandom_range(32'h1000_0000) - 32'h0800_0000;
            end else begin
               c = $urandom_range(32'h2000_0000) - 32'h1000_0000;
            end
         end
         default: begin
            case ($urandom_range(4))
               0:       c = 32'h7fff_ffff;
               1:       c = 32'h8000_0000;
               2:       c = 32'h0000_0000;
               3:       c = 32'h1000_0000;
               default: c = 32'hf000_0000;
            endcase
         end
      endcase
      return c;
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      logic [31:0]                u;
      logic signed [SAMPLE_W-1:0] s;
      u = $urandom;
      case ($urandom_range(7))
         0:       s = 24'sh7f_ffff;
         1:       s = 24'sh80_0000;
         2:       s = $signed(24'(u[7:0])) - 24'sd128;
         default: s = u[SAMPLE_W-1:0];
      endcase
      return s;
   endfunction

   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      filtered_type due;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_out.size() == 0) begin
            report_mismatch("unexpected item, sample", 0, rsp_bus.sample_out);
         end else begin
            due = pending_out.pop_front();
            if (rsp_bus.chan_out !== due.chan) begin
               report_mismatch("chan_out", due.chan, rsp_bus.chan_out);
            end
            if (rsp_bus.sample_out !== due.smp) begin
               report_mismatch("sample_out", due.smp, rsp_bus.sample_out);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("multichannel_biquad_four_forms_top: mismatch");
            $finish;
         end
      end
   end

   initial begin
      int          style;
      logic [1:0]  seg_form;
      reset             <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.chan      <= '0;
      req_bus.sample_in <= '0;
      psel              <= 1'b0;
      penable           <= 1'b0;
      pwrite            <= 1'b0;
      paddr             <= '0;
      pwdata            <= '0;

      form_cur = FORM_RESET;
      tap_b0   = B0_RESET;
      tap_b1   = '0;
      tap_b2   = '0;
      tap_fb1  = '0;
      tap_fb2  = '0;
      clear_history();

      // after reset: transposed II, unity gain, so samples pass unchanged
      add_item(3'd0, 24'sh7f_ffff, 1'b1, 24'sh7f_ffff);
      add_item(3'd7, 24'sh80_0000, 1'b1, 24'sh80_0000);
      add_item(3'd3, 24'sd0,       1'b1, 24'sd0);
      add_item(3'd5, 24'sd1,       1'b1, 24'sd1);
      // gain near +8 and -8 drives the output into saturation
      add_csr(REG_B0, 32'h7fff_ffff);
      add_item(3'd1, 24'sh7f_ffff, 1'b1, 24'sh7f_ffff);
      add_item(3'd2, 24'sh80_0000, 1'b1, 24'sh80_0000);
      add_csr(REG_B0, 32'h8000_0000);
      add_item(3'd4, 24'sh80_0000, 1'b1, 24'sh7f_ffff);
      add_item(3'd6, 24'sh7f_ffff, 1'b1, 24'sh80_0000);
      // direct form I with extreme feedback, history saturates
      add_csr(REG_B0,  32'h1000_0000);
      add_csr(REG_B1,  32'h0800_0000);
      add_csr(REG_B2,  32'hf800_0000);
      add_csr(REG_FB1, 32'h7fff_ffff);
      add_csr(REG_FB2, 32'h8000_0000);
      add_csr(REG_FORM, {30'd0, FORM_DF1});
      add_item(3'd0, 24'sh7f_ffff, 1'b0, 24'sd0);
      add_item(3'd0, 24'sh7f_ffff, 1'b0, 24'sd0);
      add_item(3'd0, 24'sh7f_ffff, 1'b0, 24'sd0);
      add_item(3'd0, 24'sh7f_ffff, 1'b0, 24'sd0);
      // same structure written again still clears the history
      add_csr(REG_FORM, {30'd0, FORM_DF1});
      add_item(3'd0, 24'sd1000,  1'b1, 24'sd1000);
      add_item(3'd0, -24'sd1000, 1'b0, 24'sd0);
      add_csr(REG_FORM, {30'd0, FORM_DF2});
      add_item(3'd1, 24'sh7f_ffff, 1'b0, 24'sd0);
      add_item(3'd1, 24'sh80_0000, 1'b0, 24'sd0);
      add_csr(REG_FORM, {30'd0, FORM_TF1});
      add_item(3'd2, 24'sh80_0000, 1'b0, 24'sd0);
      add_item(3'd2, 24'sh7f_ffff, 1'b0, 24'sd0);
      // upper data bits of the structure register are don't-care
      add_csr(REG_FORM, 32'hffff_fffb);
      add_item(3'd3, 24'sh55_5555, 1'b1, 24'sh55_5555);
      // writes beyond the last register change nothing
      add_csr(REG_SPARE6, 32'hdead_beef);
      add_csr(REG_SPARE7, 32'h0000_0000);
      add_item(3'd3, 24'shaa_aaaa, 1'b0, 24'sd0);
      add_item(3'd7, -24'sd1,      1'b0, 24'sd0);

      send_idle_pct = 32;
      recv_idle_pct = 51;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR) begin
            drain_filter();
            csr_write(plan[i].idx, plan[i].data);
         end else begin
            send_sample(plan[i].ch, plan[i].smp, plan[i].fixed, plan[i].want);
         end
      end

      for (int seg = 0; seg < SEGMENTS; seg++) begin
         case (seg / 4)
            0: begin
               send_idle_pct = 32;
               recv_idle_pct = 51;
            end
            1: begin
               send_idle_pct = 51;
               recv_idle_pct = 32;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         style    = seg % 3;
         seg_form = seg[1:0];
         drain_filter();
         csr_write(REG_FORM, {30'd0, seg_form});
         csr_write(REG_B0,  pick_tap(style, 1'b0));
         csr_write(REG_B1,  pick_tap(style, 1'b0));
         csr_write(REG_B2,  pick_tap(style, 1'b0));
         csr_write(REG_FB1, pick_tap(style, 1'b1));
         csr_write(REG_FB2, pick_tap(style, 1'b1));
         for (int n = 0; n < ITEMS_PER_SEG; n++) begin
            if (n == ITEMS_PER_SEG / 2) begin
               drain_filter();
               csr_write(REG_B1, pick_tap(style, 1'b0));
               if ($urandom_range(1) == 0) begin
                  csr_write(REG_FORM, {30'd0, seg_form});
               end
               if ($urandom_range(3) == 0) begin
                  csr_write($urandom_range(1) ? REG_SPARE6 : REG_SPARE7, $urandom);
               end
            end
            send_sample(3'($urandom_range(CHANNELS - 1)), pick_sample(), 1'b0, 24'sd0);
         end
      end

      drain_filter();
      repeat (40) @(posedge clock);
      if (mismatches == 0) begin
         $display("multichannel_biquad_four_forms_top: match");
      end else begin
         $display("multichannel_biquad_four_forms_top: mismatch");
      end
      $finish;
   end

endmodule
